FILE: rtl/core/ehx_pkg.sv
// ----------------------------------------------------------------------------
// ehx_pkg
// Shared widths, register codes, elaboration-time CORDIC table functions and a
// Q30 multiply helper for the equatorial/horizontal transform.
// ----------------------------------------------------------------------------
package ehx_pkg;

  // vector parts are Q30 two's complement
  localparam int QF        = 30;
  localparam int VW        = 36;  // vector datapath width, headroom for CORDIC gain
  localparam int MW        = 32;  // multiplier operand width
  localparam int ROT_LANES = 3;   // latitude, polar, hour angle

  localparam logic REG_SITE_LATITUDE = 1'b0;

  localparam logic [63:0] ONE60 = 64'h1000_0000_0000_0000;

  // restoring divide, elaboration use only
  function automatic logic [63:0] udiv(logic [63:0] n, logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      q = {q[62:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/m) in Q60
  function automatic logic [63:0] atan_inv(logic [63:0] m);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] k;
    logic        add;
    p   = udiv(ONE60, m);
    sum = '0;
    k   = 64'd1;
    add = 1'b1;
    for (int t = 0; t < 64; t++) begin
      if (p != '0) begin
        if (add) sum = sum + udiv(p, k);
        else     sum = sum - udiv(p, k);
        add = !add;
        p   = udiv(p, m * m);
        k   = k + 64'd2;
      end
    end
    return sum;
  endfunction

  // atan(2^-i) in Q60, i >= 1
  function automatic logic [63:0] atan_pow2(int i);
    logic [63:0] sum;
    logic        add;
    sum = '0;
    add = 1'b1;
    for (int k = 1; k <= 61; k += 2) begin
      if (i * k <= 60) begin
        if (add) sum = sum + udiv(ONE60 >> (i * k), 64'(k));
        else     sum = sum - udiv(ONE60 >> (i * k), 64'(k));
        add = !add;
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] quarter_pi();
    return 64'd4 * atan_inv(64'd5) - atan_inv(64'd239);
  endfunction

  // stage angle as a binary fraction of a turn, ab bits
  function automatic logic [63:0] atan_entry(int i, int ab);
    logic [63:0] two_pi;
    logic [63:0] r;
    logic [63:0] q;
    two_pi = 64'd8 * quarter_pi();
    r = (i == 0) ? quarter_pi() : atan_pow2(i);
    q = '0;
    for (int b = 0; b < ab; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= two_pi) begin
        r = r - two_pi;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // start value of the rotation CORDIC: 2^60 / vectoring gain of (1,0)
  function automatic logic [63:0] gain_k(int stages);
    longint x;
    longint y;
    longint dx;
    longint dy;
    x = longint'(1) <<< QF;
    y = 0;
    for (int i = 0; i < stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
      end else begin
        x = x - dx;
        y = y + dy;
      end
    end
    return (x > 0) ? udiv(ONE60, 64'(x)) : 64'd0;
  endfunction

  // Q30 product, floor rounding
  function automatic logic signed [VW-1:0] mulq(logic signed [MW-1:0] a,
                                               logic signed [MW-1:0] b);
    logic signed [2*MW-1:0] p;
    p = a * b;
    return VW'(p >>> QF);
  endfunction

endpackage

FILE: rtl/core/equatorial_horizontal_transform_top.sv
// ----------------------------------------------------------------------------
// equatorial_horizontal_transform_top
// Equatorial <-> horizontal sky coordinate conversion for one site latitude.
// ----------------------------------------------------------------------------
// Fully pipelined: one position is accepted every cycle unless the output
// stalls, and results leave in order. Each passes through the input
// register, the sine/cosine CORDIC chain, two multiply registers, the
// azimuthal atan2 chain, a length-scale register, the polar atan2 chain and
// the output register. A stall at the output freezes the whole pipe. Angles
// are binary turns (2^32 = 360 deg); tuser selects the direction: 0 gives
// azimuth/altitude from RA/dec, 1 gives RA/dec from azimuth/altitude.
module equatorial_horizontal_transform_top
  import ehx_pkg::*;
#(
  parameter int ANGLE_BITS    = 32,
  parameter int CORDIC_STAGES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // sidereal_angle, azimuthal_in, polar_in
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // azimuthal_out, polar_out
);

  localparam int AB  = ANGLE_BITS;
  localparam int NS  = CORDIC_STAGES;
  localparam int RSW = AB + 4;
  localparam int SW1 = VW + AB + 3;
  localparam int SW2 = AB + 2;

  localparam logic [AB-1:0] HALF = {1'b1, {(AB-1){1'b0}}};
  localparam logic signed [AB:0] QUART = (AB+1)'(1) <<< (AB-2);
  localparam logic signed [VW-1:0] GAIN = VW'(gain_k(NS));
  localparam logic [AB+31:0] RND = (AB+32)'(1) << (AB-1);

  function automatic logic [AB-1:0] angle_in(logic [31:0] u);
    logic [AB+31:0] w;
    w = {u, {AB{1'b0}}};
    return w[AB+31:32];
  endfunction

  function automatic logic [31:0] angle_out(logic [AB-1:0] v);
    logic [AB+31:0] w;
    w = {v, 32'd0} + RND;
    return w[AB+31:AB];
  endfunction

  // ---- configuration
  logic [31:0] site_latitude;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      site_latitude <= '0;
    end else if (cfg_wr && paddr[2] == REG_SITE_LATITUDE) begin
      site_latitude <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_SITE_LATITUDE) ? site_latitude : 32'd0;

  // ---- pipeline advance
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // ---- input register
  logic          v0;
  logic          k0;
  logic [AB-1:0] lst0;
  logic [AB-1:0] th0 [ROT_LANES];
  logic [AB-1:0] lst_in;
  logic [AB-1:0] az_in;

  assign lst_in = angle_in(s_tdata[31:0]);
  assign az_in  = angle_in(s_tdata[63:32]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k0     <= s_tuser;
      lst0   <= lst_in;
      th0[0] <= angle_in(site_latitude);
      th0[1] <= angle_in(s_tdata[95:64]);
      th0[2] <= s_tuser ? az_in : lst_in - az_in;
    end
  end

  // ---- sine/cosine chain
  logic                 rv [NS+1];
  logic signed [VW-1:0] rx [NS+1][ROT_LANES];
  logic signed [VW-1:0] ry [NS+1][ROT_LANES];
  logic signed [AB:0]   rz [NS+1][ROT_LANES];
  logic [RSW-1:0]       rs [NS+1];
  logic [2:0]           fneg;
  logic signed [AB:0]   rz0 [ROT_LANES];

  // fold into +-quarter turn; a half-turn shift negates both outputs
  always_comb begin
    for (int l = 0; l < ROT_LANES; l++) begin
      rz0[l]  = $signed({th0[l][AB-1], th0[l]});
      fneg[l] = 1'b0;
      if (rz0[l] > QUART || rz0[l] < -QUART) begin
        rz0[l]  = $signed({~th0[l][AB-1], ~th0[l][AB-1], th0[l][AB-2:0]});
        fneg[l] = 1'b1;
      end
    end
  end

  for (genvar l = 0; l < ROT_LANES; l++) begin : g_lane
    assign rx[0][l] = GAIN;
    assign ry[0][l] = '0;
    assign rz[0][l] = rz0[l];
  end

  assign rv[0] = v0;
  assign rs[0] = {fneg, lst0, k0};

  for (genvar g = 0; g < NS; g++) begin : g_rot
    ehx_rot_cell #(.ANGLE_BITS(AB), .STAGE(g), .SW(RSW)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(rv[g]), .in_x(rx[g]), .in_y(ry[g]), .in_z(rz[g]), .in_side(rs[g]),
      .out_valid(rv[g+1]), .out_x(rx[g+1]), .out_y(ry[g+1]), .out_z(rz[g+1]),
      .out_side(rs[g+1])
    );
  end

  logic signed [VW-1:0] cosv [ROT_LANES];
  logic signed [VW-1:0] sinv [ROT_LANES];
  logic                 kr;
  logic [AB-1:0]        lstr;

  assign kr   = rs[NS][0];
  assign lstr = rs[NS][AB:1];

  always_comb begin
    for (int l = 0; l < ROT_LANES; l++) begin
      cosv[l] = rs[NS][AB+1+l] ? -rx[NS][l] : rx[NS][l];
      sinv[l] = rs[NS][AB+1+l] ? -ry[NS][l] : ry[NS][l];
    end
  end

  // ---- first products: lanes are latitude, polar, hour angle / azimuth
  logic                 va;
  logic                 ka;
  logic [AB-1:0]        lsta;
  logic signed [VW-1:0] py_a, t1_a, t2_a, t3_a, t4_a, sl_a, cp_a, cx_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= rv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ka   <= kr;
      lsta <= lstr;
      py_a <= mulq(MW'(sinv[2]), MW'(cosv[1]));
      t1_a <= mulq(MW'(cosv[2]), kr ? MW'(sinv[0]) : MW'(cosv[1]));
      t2_a <= mulq(MW'(sinv[1]), MW'(cosv[0]));
      t3_a <= mulq(MW'(sinv[0]), MW'(sinv[1]));
      t4_a <= mulq(MW'(cosv[0]), MW'(cosv[1]));
      sl_a <= sinv[0];
      cp_a <= cosv[1];
      cx_a <= cosv[2];
    end
  end

  // ---- second products and sums
  logic                 vb;
  logic                 kb;
  logic [AB-1:0]        lstb;
  logic signed [VW-1:0] xb, yb, zb;
  logic signed [VW-1:0] m2, m3;

  assign m2 = mulq(MW'(t1_a), ka ? MW'(cp_a) : MW'(sl_a));
  assign m3 = mulq(MW'(t4_a), MW'(cx_a));

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kb   <= ka;
      lstb <= lsta;
      xb   <= ka ? t2_a - m2 : m2 - t2_a;
      yb   <= ka ? -py_a : py_a;
      zb   <= t3_a + m3;
    end
  end

  // ---- atan2 of the azimuthal term
  logic                 av [NS+1];
  logic signed [VW-1:0] ax [NS+1];
  logic signed [VW-1:0] ay [NS+1];
  logic signed [AB:0]   az [NS+1];
  logic [SW1-1:0]       as1 [NS+1];
  logic                 zero1, neg1;

  assign zero1  = (xb == '0) && (yb == '0);
  assign neg1   = xb < 0;
  assign av[0]  = vb;
  assign ax[0]  = neg1 ? -xb : xb;
  assign ay[0]  = neg1 ? -yb : yb;
  assign az[0]  = '0;
  assign as1[0] = {zb, zero1, neg1, lstb, kb};

  for (genvar g = 0; g < NS; g++) begin : g_vec1
    ehx_vec_cell #(.ANGLE_BITS(AB), .STAGE(g), .SW(SW1)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(av[g]), .in_x(ax[g]), .in_y(ay[g]), .in_z(az[g]), .in_side(as1[g]),
      .out_valid(av[g+1]), .out_x(ax[g+1]), .out_y(ay[g+1]), .out_z(az[g+1]),
      .out_side(as1[g+1])
    );
  end

  logic          k1;
  logic [AB-1:0] lst1;
  logic [AB-1:0] a1;

  assign k1   = as1[NS][0];
  assign lst1 = as1[NS][AB:1];
  assign a1   = as1[NS][AB+2] ? '0
              : az[NS][AB-1:0] + (as1[NS][AB+1] ? HALF : '0);

  // ---- length scale and azimuthal result
  logic                 vh;
  logic signed [VW-1:0] hh, zh;
  logic [AB-1:0]        azh;

  always_ff @(posedge clk) begin
    if (rst) begin
      vh <= 1'b0;
    end else if (adv) begin
      vh <= av[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hh  <= mulq(MW'(ax[NS]), MW'(GAIN));
      zh  <= as1[NS][SW1-1 -: VW];
      azh <= k1 ? lst1 - a1 : a1 + HALF;
    end
  end

  // ---- atan2 of the polar term
  logic                 pv [NS+1];
  logic signed [VW-1:0] px [NS+1];
  logic signed [VW-1:0] py [NS+1];
  logic signed [AB:0]   pz [NS+1];
  logic [SW2-1:0]       ps [NS+1];
  logic                 zero2, neg2;

  assign zero2 = (hh == '0) && (zh == '0);
  assign neg2  = hh < 0;
  assign pv[0] = vh;
  assign px[0] = neg2 ? -hh : hh;
  assign py[0] = neg2 ? -zh : zh;
  assign pz[0] = '0;
  assign ps[0] = {azh, zero2, neg2};

  for (genvar g = 0; g < NS; g++) begin : g_vec2
    ehx_vec_cell #(.ANGLE_BITS(AB), .STAGE(g), .SW(SW2)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(pv[g]), .in_x(px[g]), .in_y(py[g]), .in_z(pz[g]), .in_side(ps[g]),
      .out_valid(pv[g+1]), .out_x(px[g+1]), .out_y(py[g+1]), .out_z(pz[g+1]),
      .out_side(ps[g+1])
    );
  end

  logic [AB-1:0] p_res;

  assign p_res = ps[NS][1] ? '0 : pz[NS][AB-1:0] + (ps[NS][0] ? HALF : '0);

  // ---- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= pv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {angle_out(p_res), angle_out(ps[NS][SW2-1 -: AB])};
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output stalled");

  a_input_captured: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v0)
    else $error("accepted transaction not captured");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid && !v0)
    else $error("pipeline not empty after reset");

  a_stall_holds_chain: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vh) && $stable(vb))
    else $error("pipeline moved during stall");
`endif

endmodule

FILE: rtl/core/ehx_rot_cell.sv
// ----------------------------------------------------------------------------
// ehx_rot_cell
// One rotation CORDIC step for the three sine/cosine lanes, registered.
// ----------------------------------------------------------------------------
module ehx_rot_cell
  import ehx_pkg::*;
#(
  parameter int ANGLE_BITS = 32,
  parameter int STAGE      = 0,
  parameter int SW         = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [VW-1:0]    in_x [ROT_LANES],
  input  logic signed [VW-1:0]    in_y [ROT_LANES],
  input  logic signed [ANGLE_BITS:0] in_z [ROT_LANES],
  input  logic [SW-1:0]           in_side,
  output logic                    out_valid,
  output logic signed [VW-1:0]    out_x [ROT_LANES],
  output logic signed [VW-1:0]    out_y [ROT_LANES],
  output logic signed [ANGLE_BITS:0] out_z [ROT_LANES],
  output logic [SW-1:0]           out_side
);

  localparam logic signed [ANGLE_BITS:0] ATAN =
    (ANGLE_BITS+1)'(atan_entry(STAGE, ANGLE_BITS));

  logic signed [VW-1:0]         x_next [ROT_LANES];
  logic signed [VW-1:0]         y_next [ROT_LANES];
  logic signed [ANGLE_BITS:0]   z_next [ROT_LANES];

  always_comb begin
    for (int l = 0; l < ROT_LANES; l++) begin
      if (in_z[l] >= 0) begin
        x_next[l] = in_x[l] - (in_y[l] >>> STAGE);
        y_next[l] = in_y[l] + (in_x[l] >>> STAGE);
        z_next[l] = in_z[l] - ATAN;
      end else begin
        x_next[l] = in_x[l] + (in_y[l] >>> STAGE);
        y_next[l] = in_y[l] - (in_x[l] >>> STAGE);
        z_next[l] = in_z[l] + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
      out_side <= in_side;
    end
  end

endmodule

FILE: rtl/core/ehx_vec_cell.sv
// ----------------------------------------------------------------------------
// ehx_vec_cell
// One vectoring CORDIC step (atan2 and length), registered.
// ----------------------------------------------------------------------------
module ehx_vec_cell
  import ehx_pkg::*;
#(
  parameter int ANGLE_BITS = 32,
  parameter int STAGE      = 0,
  parameter int SW         = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [VW-1:0]       in_x,
  input  logic signed [VW-1:0]       in_y,
  input  logic signed [ANGLE_BITS:0] in_z,
  input  logic [SW-1:0]              in_side,
  output logic                       out_valid,
  output logic signed [VW-1:0]       out_x,
  output logic signed [VW-1:0]       out_y,
  output logic signed [ANGLE_BITS:0] out_z,
  output logic [SW-1:0]              out_side
);

  localparam logic signed [ANGLE_BITS:0] ATAN =
    (ANGLE_BITS+1)'(atan_entry(STAGE, ANGLE_BITS));

  logic signed [VW-1:0]       x_next;
  logic signed [VW-1:0]       y_next;
  logic signed [ANGLE_BITS:0] z_next;

  always_comb begin
    if (in_y >= 0) begin
      x_next = in_x + (in_y >>> STAGE);
      y_next = in_y - (in_x >>> STAGE);
      z_next = in_z + ATAN;
    end else begin
      x_next = in_x - (in_y >>> STAGE);
      y_next = in_y + (in_x >>> STAGE);
      z_next = in_z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
      out_side <= in_side;
    end
  end

endmodule
